>>> rtl/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Types and constants shared by the 1-Wire bus master modules.
// ----------------------------------------------------------------------------
package owm_pkg;

  // Request codes on the input channel
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_RESET = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_RECOVERY = 3'd5;

  // Register width and reset values
  localparam int unsigned CFG_W = 16;
  localparam logic [CFG_W-1:0] RESET_LOW_DEF     = 16'd480;
  localparam logic [CFG_W-1:0] PRESENCE_WAIT_DEF = 16'd50;
  localparam logic [CFG_W-1:0] SLOT_LOW_DEF      = 16'd1;
  localparam logic [CFG_W-1:0] WRITE_HOLD_DEF    = 16'd100;
  localparam logic [CFG_W-1:0] READ_SAMPLE_DEF   = 16'd100;
  localparam logic [CFG_W-1:0] READ_RECOVERY_DEF = 16'd100;

  // Bits per byte transfer
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_SLOT_LOW = 3'd3,
    PH_WR_HOLD  = 3'd4,
    PH_RD_WAIT  = 3'd5,
    PH_RD_RECOV = 3'd6
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low_ticks;
    logic [CFG_W-1:0] presence_wait_ticks;
    logic [CFG_W-1:0] slot_low_ticks;
    logic [CFG_W-1:0] write_hold_ticks;
    logic [CFG_W-1:0] read_sample_ticks;
    logic [CFG_W-1:0] read_recovery_ticks;
  } cfg_t;

  // Sequencer state apart from the tick counter
  typedef struct packed {
    phase_t     phase;
    logic [1:0] operation;
    logic [7:0] shift_bits;
    logic [3:0] bits_left;
  } seq_t;

  typedef struct packed {
    logic       drive_low;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
    logic       refused;
  } res_t;

endpackage

>>> rtl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master stepped by one-microsecond tick requests: bus reset with
// presence detect, write byte and read byte, LSB first.
// ----------------------------------------------------------------------------
// Results: each accepted request's result is registered in the result buffer.
// Throughput: one request per cycle while in_stall is low; each request is one counter and phase
// update in a single combinational step ahead of the result buffer.
// Reset: synchronous, active low; sequencer idles, registers take defaults.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [owm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [owm_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_req_type,
  input  logic [7:0]                      in_tx_byte,
  input  logic                            in_line_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_drive_low,
  output logic                            out_done_res,
  output logic                            out_presence,
  output logic [7:0]                      out_rx_byte,
  output logic                            out_refused
);
  import owm_pkg::*;

  cfg_t                   cfg_r;
  seq_t                   seq_r, seq_nxt;
  logic [COUNT_WIDTH-1:0] tick_count_r, tick_count_nxt;
  res_t                   step_res;
  res_t                   out_res;
  logic                   in_accept;

  assign in_accept = in_valid && !in_stall;

  // Configuration registers; writes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks     <= RESET_LOW_DEF;
      cfg_r.presence_wait_ticks <= PRESENCE_WAIT_DEF;
      cfg_r.slot_low_ticks      <= SLOT_LOW_DEF;
      cfg_r.write_hold_ticks    <= WRITE_HOLD_DEF;
      cfg_r.read_sample_ticks   <= READ_SAMPLE_DEF;
      cfg_r.read_recovery_ticks <= READ_RECOVERY_DEF;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RESET_LOW:     cfg_r.reset_low_ticks     <= cfg_data;
        CFG_PRESENCE_WAIT: cfg_r.presence_wait_ticks <= cfg_data;
        CFG_SLOT_LOW:      cfg_r.slot_low_ticks      <= cfg_data;
        CFG_WRITE_HOLD:    cfg_r.write_hold_ticks    <= cfg_data;
        CFG_READ_SAMPLE:   cfg_r.read_sample_ticks   <= cfg_data;
        CFG_READ_RECOVERY: cfg_r.read_recovery_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  owm_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .req_type       (in_req_type),
    .tx_byte        (in_tx_byte),
    .line_level     (in_line_level),
    .cfg            (cfg_r),
    .seq            (seq_r),
    .tick_count     (tick_count_r),
    .seq_nxt        (seq_nxt),
    .tick_count_nxt (tick_count_nxt),
    .res            (step_res)
  );

  // Advance the sequencer on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r.phase      <= PH_IDLE;
      seq_r.operation  <= REQ_TICK;
      seq_r.shift_bits <= 8'd0;
      seq_r.bits_left  <= 4'd0;
      tick_count_r     <= '0;
    end else if (in_accept) begin
      seq_r        <= seq_nxt;
      tick_count_r <= tick_count_nxt;
    end
  end

  owm_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_data  (step_res),
    .push_stall (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_res)
  );

  assign out_drive_low = out_res.drive_low;
  assign out_done_res  = out_res.done_res;
  assign out_presence  = out_res.presence;
  assign out_rx_byte   = out_res.rx_byte;
  assign out_refused   = out_res.refused;

endmodule

>>> rtl/owm_step.sv
// ----------------------------------------------------------------------------
// owm_step
// Next-state and result logic for one tick request of the bus sequencer.
// ----------------------------------------------------------------------------
module owm_step #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic [1:0]             req_type,
  input  logic [7:0]             tx_byte,
  input  logic                   line_level,
  input  owm_pkg::cfg_t          cfg,
  input  owm_pkg::seq_t          seq,
  input  logic [COUNT_WIDTH-1:0] tick_count,
  output owm_pkg::seq_t          seq_nxt,
  output logic [COUNT_WIDTH-1:0] tick_count_nxt,
  output owm_pkg::res_t          res
);
  import owm_pkg::*;

  localparam int unsigned DW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [DW-1:0] CNT_MAX_W = DW'(CNT_MAX);
  localparam logic [DW-1:0] ONE_W = DW'(1);

  logic                   cmd;
  logic                   start;
  phase_t                 ph;
  logic [1:0]             op;
  logic [COUNT_WIDTH-1:0] tc;
  logic [7:0]             sb;
  logic [3:0]             bl;
  logic [CFG_W-1:0]       dur_raw;
  logic                   dur_ok;
  logic [DW-1:0]          raw_w;
  logic [DW-1:0]          dur_w;
  logic [COUNT_WIDTH-1:0] tc_inc;
  logic                   expire;
  logic [7:0]             sb_wr;
  logic [7:0]             sb_rd;
  logic                   bit_done;
  logic [3:0]             bl_dec;
  logic                   last_bit;

  // Take a new command only when idle
  assign cmd   = (req_type != REQ_TICK);
  assign start = cmd && (seq.phase == PH_IDLE);

  always_comb begin
    if (start) begin
      ph = (req_type == REQ_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
      op = req_type;
      tc = '0;
      sb = (req_type == REQ_WRITE) ? tx_byte : 8'd0;
      bl = BYTE_BITS;
    end else begin
      ph = seq.phase;
      op = seq.operation;
      tc = tick_count;
      sb = seq.shift_bits;
      bl = seq.bits_left;
    end
  end

  // Pick the duration of the current phase
  always_comb begin
    dur_ok = 1'b1;
    unique case (ph)
      PH_RST_LOW:  dur_raw = cfg.reset_low_ticks;
      PH_RST_WAIT: dur_raw = cfg.presence_wait_ticks;
      PH_SLOT_LOW: dur_raw = cfg.slot_low_ticks;
      PH_WR_HOLD:  dur_raw = cfg.write_hold_ticks;
      PH_RD_WAIT:  dur_raw = cfg.read_sample_ticks;
      PH_RD_RECOV: dur_raw = cfg.read_recovery_ticks;
      default: begin
        dur_raw = '0;
        dur_ok  = 1'b0;
      end
    endcase
  end

  // Treat zero as one, cut at the counter limit
  assign raw_w = DW'(dur_raw);
  assign dur_w = (raw_w == '0) ? ONE_W : ((raw_w > CNT_MAX_W) ? CNT_MAX_W : raw_w);

  // Saturating tick counter and phase end
  assign tc_inc = (tc == CNT_MAX) ? tc : tc + 1'b1;
  assign expire = dur_ok && (ph != PH_IDLE) && (DW'(tc_inc) >= dur_w);

  // Shift data and bit bookkeeping
  assign sb_wr    = {1'b0, sb[7:1]};
  assign sb_rd    = {line_level, sb[7:1]};
  assign bl_dec   = (bl != 4'd0) ? bl - 4'd1 : 4'd0;
  assign last_bit = (bl_dec == 4'd0);

  always_comb begin
    bit_done = 1'b0;
    if (expire) begin
      unique case (ph)
        PH_WR_HOLD:  bit_done = 1'b1;
        PH_RD_WAIT:  bit_done = (cfg.read_recovery_ticks == '0);
        PH_RD_RECOV: bit_done = 1'b1;
        default:     bit_done = 1'b0;
      endcase
    end
  end

  // Next state
  always_comb begin
    seq_nxt.operation  = op;
    seq_nxt.shift_bits = sb;
    seq_nxt.bits_left  = bl;
    seq_nxt.phase      = ph;
    tick_count_nxt     = tc;
    if (ph != PH_IDLE) begin
      if (!dur_ok) begin
        seq_nxt.phase  = PH_IDLE;
        tick_count_nxt = '0;
      end else if (!expire) begin
        tick_count_nxt = tc_inc;
      end else begin
        tick_count_nxt = '0;
        unique case (ph)
          PH_RST_LOW:  seq_nxt.phase = PH_RST_WAIT;
          PH_RST_WAIT: seq_nxt.phase = PH_IDLE;
          PH_SLOT_LOW: seq_nxt.phase = (op == REQ_WRITE) ? PH_WR_HOLD : PH_RD_WAIT;
          PH_WR_HOLD:  seq_nxt.shift_bits = sb_wr;
          PH_RD_WAIT: begin
            seq_nxt.shift_bits = sb_rd;
            if (!bit_done) begin
              seq_nxt.phase = PH_RD_RECOV;
            end
          end
          default: seq_nxt.phase = ph;
        endcase
        if (bit_done) begin
          seq_nxt.bits_left = bl_dec;
          seq_nxt.phase     = last_bit ? PH_IDLE : PH_SLOT_LOW;
        end
      end
    end
  end

  // Result flags
  always_comb begin
    res.refused   = cmd && !start;
    res.presence  = 1'b0;
    res.done_res  = 1'b0;
    res.rx_byte   = 8'd0;
    unique case (ph)
      PH_RST_LOW:  res.drive_low = 1'b1;
      PH_SLOT_LOW: res.drive_low = 1'b1;
      PH_WR_HOLD:  res.drive_low = ~sb[0];
      default:     res.drive_low = 1'b0;
    endcase
    if (expire && (ph == PH_RST_WAIT)) begin
      res.done_res = 1'b1;
      res.presence = ~line_level;
    end
    if (bit_done && last_bit) begin
      res.done_res = 1'b1;
      if (op == REQ_READ) begin
        res.rx_byte = (ph == PH_RD_WAIT) ? sb_rd : sb;
      end
    end
  end

endmodule

>>> rtl/owm_obuf.sv
// ----------------------------------------------------------------------------
// owm_obuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module owm_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  owm_pkg::res_t push_data,
  output logic          push_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output owm_pkg::res_t out_data
);
  import owm_pkg::*;

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic push;
  logic pop;

  assign push_stall = skid_valid_r;
  assign push       = push_valid && !skid_valid_r;
  assign pop        = main_valid_r && !out_stall;

  // Move results between the two entries
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

>>> test/tb_one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master
// Self-checking bench for the 1-Wire bus master. A short table covers idle
// ticks, the timing extremes, refused requests and every command; random
// command sequences under several timing settings follow. Every result is compared
// field by field against its table value or a cycle-free model of the sequencer.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;
  import owm_pkg::*;

  localparam int unsigned COUNT_W        = 16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_OFF_LEN   = 400;
  localparam int unsigned ROUND_ITEMS    = 180;
  localparam int unsigned N_ROUNDS       = 8;

  // Indexes past the register list; writes there are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_NONE_LO = CFG_READ_RECOVERY + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE_HI = '1;

  // Results that can be read straight off the protocol
  localparam res_t RES_QUIET      = '0;
  localparam res_t RES_PULL       = '{drive_low: 1'b1, default: '0};
  localparam res_t RES_FOUND_BUSY = '{done_res: 1'b1, presence: 1'b1, refused: 1'b1,
                                      default: '0};
  localparam res_t RES_NO_DEVICE  = '{done_res: 1'b1, default: '0};

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_RUN} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    logic [1:0]           req;
    logic [7:0]           txb;
    logic                 lvl;
    logic                 typed;
    res_t                 want;
  } step_row_t;

  localparam int unsigned N_ROWS = 20;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_req_type;
  logic [7:0]           in_tx_byte;
  logic                 in_line_level;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_drive_low;
  logic                 out_done_res;
  logic                 out_presence;
  logic [7:0]           out_rx_byte;
  logic                 out_refused;

  one_wire_bus_master #(.COUNT_WIDTH(COUNT_W)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_tx_byte   (in_tx_byte),
    .in_line_level(in_line_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_drive_low(out_drive_low),
    .out_done_res (out_done_res),
    .out_presence (out_presence),
    .out_rx_byte  (out_rx_byte),
    .out_refused  (out_refused)
  );

  // Sequencer mirror
  cfg_t               timing;
  phase_t             bus_phase;
  logic [1:0]         bus_op;
  logic [COUNT_W-1:0] tick_cnt;
  logic [7:0]         shreg;
  logic [3:0]         bits_left;

  res_t        bus_results_q[$];
  step_row_t   steps [N_ROWS];
  logic        in_took;
  logic        row_typed;
  res_t        row_want;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  bit          hold_off_req;
  bit          hold_off_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned at_least_one(logic [CFG_W-1:0] ticks);
    return (ticks == '0) ? 1 : int'(ticks);
  endfunction

  // Advance the mirror by one request and return the result it owes
  function automatic res_t predict_bus_tick(logic [1:0] req, logic [7:0] txb, logic lvl);
    res_t        r;
    int unsigned dur;
    bit          bit_end;
    r = '0;
    dur = 0;
    bit_end = 1'b0;
    if (req != REQ_TICK) begin
      if (bus_phase == PH_IDLE) begin
        bus_op = req;
        tick_cnt = '0;
        bits_left = BYTE_BITS;
        shreg = (req == REQ_WRITE) ? txb : 8'h00;
        if (req == REQ_RESET) bus_phase = PH_RST_LOW;
        else bus_phase = PH_SLOT_LOW;
      end else begin
        r.refused = 1'b1;
      end
    end
    if (bus_phase != PH_IDLE) begin
      case (bus_phase)
        PH_RST_LOW: begin
          dur = at_least_one(timing.reset_low_ticks);
          r.drive_low = 1'b1;
        end
        PH_RST_WAIT: dur = at_least_one(timing.presence_wait_ticks);
        PH_SLOT_LOW: begin
          dur = at_least_one(timing.slot_low_ticks);
          r.drive_low = 1'b1;
        end
        PH_WR_HOLD: begin
          dur = at_least_one(timing.write_hold_ticks);
          r.drive_low = ~shreg[0];
        end
        PH_RD_WAIT:  dur = at_least_one(timing.read_sample_ticks);
        PH_RD_RECOV: dur = at_least_one(timing.read_recovery_ticks);
        default:     dur = 0;
      endcase
      if (dur == 0) begin
        bus_phase = PH_IDLE;
        tick_cnt = '0;
      end else begin
        // Saturate the counter at its width
        if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= dur) begin
          tick_cnt = '0;
          case (bus_phase)
            PH_RST_LOW: bus_phase = PH_RST_WAIT;
            PH_RST_WAIT: begin
              r.presence = ~lvl;
              r.done_res = 1'b1;
              bus_phase = PH_IDLE;
            end
            PH_SLOT_LOW: begin
              if (bus_op == REQ_WRITE) bus_phase = PH_WR_HOLD;
              else bus_phase = PH_RD_WAIT;
            end
            PH_WR_HOLD: begin
              shreg = shreg >> 1;
              bit_end = 1'b1;
            end
            PH_RD_WAIT: begin
              shreg = {lvl, shreg[7:1]};
              // Zero recovery skips straight to the next slot
              if (timing.read_recovery_ticks == '0) bit_end = 1'b1;
              else bus_phase = PH_RD_RECOV;
            end
            default: bit_end = 1'b1;
          endcase
          if (bit_end) begin
            if (bits_left != '0) bits_left = bits_left - 1'b1;
            if (bits_left == '0) begin
              r.done_res = 1'b1;
              if (bus_op == REQ_READ) r.rx_byte = shreg;
              bus_phase = PH_IDLE;
            end else begin
              bus_phase = PH_SLOT_LOW;
            end
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [1:0] pick_cmd();
    case ($urandom_range(0, 2))
      0:       return REQ_RESET;
      1:       return REQ_WRITE;
      default: return REQ_READ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH %s", msg);
    mismatches++;
  endtask

  // Compare one result with the oldest pending expectation
  task automatic check_result();
    res_t w;
    if (bus_results_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no request pending", results_seen));
    end else begin
      w = bus_results_q.pop_front();
      if (out_drive_low !== w.drive_low)
        report_mismatch($sformatf("result %0d drive_low got %0h want %0h",
                                  results_seen, out_drive_low, w.drive_low));
      if (out_done_res !== w.done_res)
        report_mismatch($sformatf("result %0d done_res got %0h want %0h",
                                  results_seen, out_done_res, w.done_res));
      if (out_presence !== w.presence)
        report_mismatch($sformatf("result %0d presence got %0h want %0h",
                                  results_seen, out_presence, w.presence));
      if (out_rx_byte !== w.rx_byte)
        report_mismatch($sformatf("result %0d rx_byte got %0h want %0h",
                                  results_seen, out_rx_byte, w.rx_byte));
      if (out_refused !== w.refused)
        report_mismatch($sformatf("result %0d refused got %0h want %0h",
                                  results_seen, out_refused, w.refused));
    end
    results_seen++;
  endtask

  // Sample both handshakes, predict on request, check on result, watch for hangs
  always @(posedge clk) begin
    in_took = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        row_want = row_typed ? row_want :
                   predict_bus_tick(in_req_type, in_tx_byte, in_line_level);
        if (row_typed) void'(predict_bus_tick(in_req_type, in_tx_byte, in_line_level));
        bus_results_q.push_back(row_want);
      end
      if (in_took || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: stall in segments of random style, plus one long hold-off
  initial begin
    int unsigned mode;
    int unsigned seg;
    out_stall = 1'b0;
    forever begin
      if (hold_off_req && !hold_off_done) begin
        repeat (HOLD_OFF_LEN) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_off_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      seg = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(1, 40);
      repeat (seg) begin
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= 1'b1;
        endcase
      end
    end
  end

  // Offer one request, after a gap when the current burst is used up
  task automatic put_item(logic [1:0] req, logic [7:0] txb, logic lvl,
                          logic typed, res_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
    in_req_type <= req;
    in_tx_byte <= txb;
    in_line_level <= lvl;
    in_valid <= 1'b1;
    row_typed = typed;
    row_want = want;
    do @(negedge clk); while (!in_took);
    items_sent++;
  endtask

  // Tick until the running command is over; optionally slip in refused commands
  task automatic run_to_idle(bit with_noise);
    logic [1:0] req;
    while (bus_phase != PH_IDLE) begin
      req = (with_noise && $urandom_range(0, 15) == 0) ? pick_cmd() : REQ_TICK;
      put_item(req, 8'($urandom), 1'($urandom), 1'b0, RES_QUIET);
    end
  endtask

  // Drop the request and hold until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (bus_results_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_RESET_LOW:     timing.reset_low_ticks = val;
      CFG_PRESENCE_WAIT: timing.presence_wait_ticks = val;
      CFG_SLOT_LOW:      timing.slot_low_ticks = val;
      CFG_WRITE_HOLD:    timing.write_hold_ticks = val;
      CFG_READ_SAMPLE:   timing.read_sample_ticks = val;
      CFG_READ_RECOVERY: timing.read_recovery_ticks = val;
      default: ;
    endcase
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int unsigned          round;
    int unsigned          round_start;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_req_type = REQ_TICK;
    in_tx_byte = '0;
    in_line_level = 1'b1;
    in_took = 1'b0;
    row_typed = 1'b0;
    row_want = RES_QUIET;
    items_sent = 0;
    results_seen = 0;
    mismatches = 0;
    quiet_cycles = 0;
    burst_left = 0;
    hold_off_req = 1'b0;
    hold_off_done = 1'b0;

    timing = '{RESET_LOW_DEF, PRESENCE_WAIT_DEF, SLOT_LOW_DEF,
               WRITE_HOLD_DEF, READ_SAMPLE_DEF, READ_RECOVERY_DEF};
    bus_phase = PH_IDLE;
    bus_op = REQ_TICK;
    tick_cnt = '0;
    shreg = '0;
    bits_left = '0;

    steps = '{
      // idle ticks give quiet results
      '{ROW_ITEM, '0, '0, REQ_TICK, 8'h00, 1'b1, 1'b1, RES_QUIET},
      '{ROW_ITEM, '0, '0, REQ_TICK, 8'hFF, 1'b0, 1'b1, RES_QUIET},
      // shortest timing; zero slot acts as one, zero recovery is skipped
      '{ROW_CFG, CFG_RESET_LOW,     16'd1, REQ_TICK, 8'h00, 1'b0, 1'b0, RES_QUIET},
      '{ROW_CFG, CFG_PRESENCE_WAIT, 16'd1, REQ_TICK, 8'h00, 1'b0, 1'b0, RES_QUIET},
      '{ROW_CFG, CFG_SLOT_LOW,      16'd0, REQ_TICK, 8'h00, 1'b0, 1'b0, RES_QUIET},
      '{ROW_CFG, CFG_WRITE_HOLD,    16'd1, REQ_TICK, 8'h00, 1'b0, 1'b0, RES_QUIET},
      '{ROW_CFG, CFG_READ_SAMPLE,   16'd1, REQ_TICK, 8'h00, 1'b0, 1'b0, RES_QUIET},
      '{ROW_CFG, CFG_READ_RECOVERY, 16'd0, REQ_TICK, 8'h00, 1'b0, 1'b0, RES_QUIET},
      '{ROW_CFG, CFG_NONE_HI,  16'hFFFF, REQ_TICK, 8'h00, 1'b0, 1'b0, RES_QUIET},
      // reset with a device answering; a write during it is refused
      '{ROW_ITEM, '0, '0, REQ_RESET, 8'h00, 1'b1, 1'b1, RES_PULL},
      '{ROW_ITEM, '0, '0, REQ_WRITE, 8'h3C, 1'b0, 1'b1, RES_FOUND_BUSY},
      // reset with an empty bus
      '{ROW_ITEM, '0, '0, REQ_RESET, 8'h00, 1'b0, 1'b1, RES_PULL},
      '{ROW_ITEM, '0, '0, REQ_TICK,  8'h00, 1'b1, 1'b1, RES_NO_DEVICE},
      '{ROW_RUN,  '0, '0, REQ_WRITE, 8'hA5, 1'b0, 1'b0, RES_QUIET},
      '{ROW_RUN,  '0, '0, REQ_READ,  8'h00, 1'b1, 1'b0, RES_QUIET},
      '{ROW_CFG, CFG_READ_RECOVERY, 16'd3, REQ_TICK, 8'h00, 1'b0, 1'b0, RES_QUIET},
      '{ROW_RUN,  '0, '0, REQ_READ,  8'hFF, 1'b0, 1'b0, RES_QUIET},
      '{ROW_RUN,  '0, '0, REQ_WRITE, 8'h00, 1'b1, 1'b0, RES_QUIET},
      // long reset pulse
      '{ROW_CFG, CFG_RESET_LOW, 16'd120, REQ_TICK, 8'h00, 1'b0, 1'b0, RES_QUIET},
      '{ROW_RUN,  '0, '0, REQ_RESET, 8'hFF, 1'b1, 1'b0, RES_QUIET}
    };

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    foreach (steps[i]) begin
      case (steps[i].kind)
        ROW_CFG: begin
          drain();
          write_reg(steps[i].reg_idx, steps[i].reg_val);
        end
        ROW_ITEM: put_item(steps[i].req, steps[i].txb, steps[i].lvl,
                           steps[i].typed, steps[i].want);
        default: begin
          put_item(steps[i].req, steps[i].txb, steps[i].lvl, 1'b0, RES_QUIET);
          run_to_idle(1'b0);
        end
      endcase
    end

    // Random command sequences, one timing setting per round
    for (round = 0; round < N_ROUNDS; round++) begin
      drain();
      for (idx = CFG_RESET_LOW; idx <= CFG_READ_RECOVERY; idx++) begin
        if (round == 0) val = 16'd1;
        else if (round == 1) val = '0;
        else val = CFG_W'($urandom_range(0, 5));
        write_reg(idx, val);
      end
      write_reg(CFG_IDX_W'($urandom_range(CFG_NONE_LO, CFG_NONE_HI)), CFG_W'($urandom));
      // Start the long receiver hold-off while requests keep coming
      if (round == 0) hold_off_req = 1'b1;
      round_start = items_sent;
      while (items_sent - round_start < ROUND_ITEMS) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 3))
            put_item(REQ_TICK, 8'($urandom), 1'($urandom), 1'b0, RES_QUIET);
        end else begin
          put_item(pick_cmd(), 8'($urandom), 1'($urandom), 1'b0, RES_QUIET);
          run_to_idle(1'b1);
        end
      end
    end

    // Let the last results out, then watch for strays
    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && bus_results_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
